FILE: src/rsbc_pkg.sv
// ----------------------------------------------------------------------------
// rsbc_pkg
// Shared widths, constants and register map of the RLE sprite blit clipper.
// ----------------------------------------------------------------------------
package rsbc_pkg;

    // framebuffer defaults
    localparam int FB_WIDTH_DEF  = 320;
    localparam int FB_HEIGHT_DEF = 240;

    // payload widths
    localparam int WORD_W  = 16;
    localparam int ADDR_W  = 17;
    localparam int POS_W   = 17;
    localparam int COUNT_W = 15;
    localparam int COORD_W = 16;

    // header word layout
    localparam int SPAN_BIT = 15;

    // column saturation point, always off screen
    localparam logic signed [POS_W-1:0] COL_MAX = 17'sd65535;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_ORIGIN_X     = 2'd0,
        REG_ORIGIN_Y     = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } reg_index_t;

endpackage

FILE: src/rsbc_stream_if.sv
// ----------------------------------------------------------------------------
// rsbc_stream_if
// Valid/ready channel carrying one word of the encoded sprite stream.
// ----------------------------------------------------------------------------
interface rsbc_stream_if import rsbc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] rle_word;
    logic              start_of_image;

    modport source (output valid, output rle_word, output start_of_image, input ready);
    modport sink   (input valid, input rle_word, input start_of_image, output ready);

endinterface

FILE: src/rsbc_pixel_if.sv
// ----------------------------------------------------------------------------
// rsbc_pixel_if
// Valid/ready channel carrying one framebuffer pixel write.
// ----------------------------------------------------------------------------
interface rsbc_pixel_if import rsbc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] fb_address;
    logic [WORD_W-1:0] pixel_value;

    modport source (output valid, output fb_address, output pixel_value, input ready);
    modport sink   (input valid, input fb_address, input pixel_value, output ready);

endinterface

FILE: src/rle_sprite_blit_clipper.sv
// ----------------------------------------------------------------------------
// rle_sprite_blit_clipper
// Decodes an RLE sprite stream into clipped framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Takes one stream word per cycle while the pixel side does not stall, and
// gives at most one pixel write per word. A word is captured in an input
// register, decoded against the position state when the output register
// can take it, and a visible pixel lands in the output register, which
// offers the write on the pixel channel.
// The input side stays ready while the output register is empty or being
// drained; stream.ready follows pixels.ready combinationally. Nothing is
// drawn until a word with start_of_image set arrives; origin_y,
// image_height and origin_x are sampled there, origin_x again at each row end.
module rle_sprite_blit_clipper import rsbc_pkg::*; #(
    parameter int FB_WIDTH  = FB_WIDTH_DEF,
    parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    rsbc_stream_if.sink        stream,
    rsbc_pixel_if.source       pixels,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic signed [POS_W:0]   FbHeightS = (POS_W+1)'(FB_HEIGHT);
    localparam logic        [POS_W-1:0] FbHeightU = POS_W'(FB_HEIGHT);
    localparam logic        [POS_W-1:0] FbWidthU  = POS_W'(FB_WIDTH);
    localparam logic        [ADDR_W-1:0] FbWidthA = ADDR_W'(FB_WIDTH);

    // configuration registers
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic        [COUNT_W-1:0] image_height_reg;

    // input register
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_sof_reg;

    // decode state
    logic signed [POS_W-1:0]   cur_col_reg, cur_col_next;
    logic signed [POS_W-1:0]   cur_row_reg, cur_row_next;
    logic signed [POS_W-1:0]   end_row_reg, end_row_next;
    logic        [COUNT_W-1:0] pixels_left_reg, pixels_left_next;
    logic                      finished_reg, finished_next;

    // output register
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [WORD_W-1:0] out_pixel_reg;

    logic                      fire;
    logic                      produce;
    logic                      cfg_write;
    reg_index_t                cfg_index;
    logic signed [POS_W-1:0]   col_e, row_e, end_e;
    logic                      fin_e;
    logic signed [POS_W-1:0]   ox_ext, oy_ext;
    logic signed [POS_W:0]     end_sum;
    logic signed [POS_W-1:0]   end_load;
    logic signed [POS_W:0]     col_sum;
    logic [COUNT_W-1:0]        count;
    logic [COUNT_W-1:0]        step;
    logic                      visible;
    logic signed [POS_W-1:0]   row_inc;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            image_height_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= pwdata[COORD_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_ORIGIN_X:     prdata = {{(PDATA_W-COORD_W){1'b0}}, origin_x_reg};
            REG_ORIGIN_Y:     prdata = {{(PDATA_W-COORD_W){1'b0}}, origin_y_reg};
            REG_IMAGE_HEIGHT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, image_height_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign fire         = in_valid_reg && (!out_valid_reg || pixels.ready);
    assign stream.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (stream.ready)
            in_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_word_reg <= stream.rle_word;
            in_sof_reg  <= stream.start_of_image;
        end
    end

    // ------------------------------------------------------------------
    // decode
    // ------------------------------------------------------------------
    assign ox_ext   = {origin_x_reg[COORD_W-1], origin_x_reg};
    assign oy_ext   = {origin_y_reg[COORD_W-1], origin_y_reg};
    assign end_sum  = {{2{origin_y_reg[COORD_W-1]}}, origin_y_reg}
                    + $signed({3'b000, image_height_reg});
    assign end_load = (end_sum > FbHeightS) ? $signed(FbHeightU) : end_sum[POS_W-1:0];

    // start word reloads position before it is decoded as a header
    assign col_e = in_sof_reg ? ox_ext   : cur_col_reg;
    assign row_e = in_sof_reg ? oy_ext   : cur_row_reg;
    assign end_e = in_sof_reg ? end_load : end_row_reg;
    assign fin_e = in_sof_reg ? !(oy_ext < end_load) : finished_reg;

    assign count   = in_word_reg[COUNT_W-1:0];
    assign row_inc = row_e + POS_W'(1);

    // pixel path only runs with a span open, never on a start word
    assign visible = !cur_row_reg[POS_W-1] && (cur_row_reg[POS_W-1:0] < FbHeightU)
                  && !cur_col_reg[POS_W-1] && (cur_col_reg[POS_W-1:0] < FbWidthU);
    assign out_addr_next = cur_row_reg[ADDR_W-1:0] * FbWidthA + cur_col_reg[ADDR_W-1:0];

    // saturating column advance
    assign step    = (!in_sof_reg && pixels_left_reg != '0) ? COUNT_W'(1) : count;
    assign col_sum = {col_e[POS_W-1], col_e} + $signed({3'b000, step});

    always_comb
    begin
        cur_col_next     = col_e;
        cur_row_next     = row_e;
        end_row_next     = end_e;
        pixels_left_next = in_sof_reg ? '0 : pixels_left_reg;
        finished_next    = fin_e;
        produce          = 1'b0;
        if (!fin_e)
        begin
            if (!in_sof_reg && pixels_left_reg != '0)
            begin
                pixels_left_next = pixels_left_reg - COUNT_W'(1);
                produce          = visible;
                cur_col_next     = (col_sum > $signed({1'b0, COL_MAX})) ? COL_MAX
                                                                        : col_sum[POS_W-1:0];
            end
            else if (in_word_reg[SPAN_BIT])
            begin
                pixels_left_next = count;
            end
            else if (count != '0)
            begin
                cur_col_next = (col_sum > $signed({1'b0, COL_MAX})) ? COL_MAX
                                                                    : col_sum[POS_W-1:0];
            end
            else
            begin
                // end of row
                cur_col_next  = ox_ext;
                cur_row_next  = row_inc;
                finished_next = !(row_inc < end_e);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            end_row_reg     <= '0;
            pixels_left_reg <= '0;
            finished_reg    <= 1'b1;
        end
        else if (fire)
        begin
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            end_row_reg     <= end_row_next;
            pixels_left_reg <= pixels_left_next;
            finished_reg    <= finished_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= produce;
        else if (pixels.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            out_addr_reg  <= out_addr_next;
            out_pixel_reg <= in_word_reg;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.fb_address  = out_addr_reg;
    assign pixels.pixel_value = out_pixel_reg;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the RLE sprite blit clipper. Directed images cover
// idle words before the first start, empty images, right and bottom clips,
// rows above the framebuffer, column saturation and restarts in mid-span.
// Random phases then reprogram the origin and height registers and feed
// whole encoded images with random content, mixed with truncated images and
// noise. A behavioral decoder tracks the position state and predicts each
// framebuffer write, which is checked against the pixel channel in order.
// ----------------------------------------------------------------------------
module tb_top;
    import rsbc_pkg::*;

    localparam int FB_W          = FB_WIDTH_DEF;
    localparam int FB_H          = FB_HEIGHT_DEF;
    localparam int RANDOM_WORDS  = 1850;
    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_TRIGGER  = 300;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              sof;
    } rle_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] value;
    } pixel_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // stream source side
    logic              drv_valid = 1'b0;
    logic [WORD_W-1:0] drv_word = '0;
    logic              drv_sof = 1'b0;
    // pixel sink side
    logic              rcv_ready = 1'b0;
    // register port
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    rsbc_stream_if stream_ch ();
    rsbc_pixel_if  pixel_ch ();

    assign stream_ch.valid          = drv_valid;
    assign stream_ch.rle_word       = drv_word;
    assign stream_ch.start_of_image = drv_sof;
    assign pixel_ch.ready           = rcv_ready;

    rle_sprite_blit_clipper dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_ch),
        .pixels  (pixel_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // register shadows
    logic signed [COORD_W-1:0] cfg_org_x = '0;
    logic signed [COORD_W-1:0] cfg_org_y = '0;
    logic [COUNT_W-1:0]        cfg_height = '0;

    // decoder position state
    logic signed [POS_W-1:0] col_pos = '0;
    logic signed [POS_W-1:0] row_pos = '0;
    logic signed [POS_W-1:0] row_end = '0;
    logic [COUNT_W-1:0]      span_left = '0;
    bit                      drawing = 1'b0;

    rle_item_t    words_to_send[$];
    pixel_write_t writes_due[$];

    int words_queued = 0;
    int words_accepted = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int mode_left = 0;
    int rcv_mode = 0;
    bit long_hold_done = 1'b0;

    // decode one accepted word, queue the framebuffer write it causes
    task automatic blit_word(input logic [WORD_W-1:0] w, input logic sof);
        int           row_limit;
        int           step;
        int           next_col;
        pixel_write_t pw;
        step = 0;
        if (sof) begin
            col_pos = cfg_org_x;
            row_pos = cfg_org_y;
            row_limit = int'(cfg_org_y) + int'(cfg_height);
            row_end = (row_limit > FB_H) ? POS_W'(FB_H) : POS_W'(row_limit);
            span_left = '0;
            drawing = (row_pos < row_end);
        end
        if (drawing) begin
            if (span_left != 0) begin
                span_left = span_left - 1'b1;
                if (row_pos >= 0 && row_pos < FB_H && col_pos >= 0 && col_pos < FB_W) begin
                    pw.addr = ADDR_W'(int'(row_pos) * FB_W + int'(col_pos));
                    pw.value = w;
                    writes_due.push_back(pw);
                end
                step = 1;
            end else if (w[SPAN_BIT]) begin
                span_left = w[COUNT_W-1:0];
            end else if (w[COUNT_W-1:0] != 0) begin
                step = int'(w[COUNT_W-1:0]);
            end else begin
                // end of row
                col_pos = cfg_org_x;
                row_pos = row_pos + 1;
                if (row_pos >= row_end)
                    drawing = 1'b0;
            end
            if (step != 0) begin
                next_col = int'(col_pos) + step;
                col_pos = (next_col > int'(COL_MAX)) ? COL_MAX : POS_W'(next_col);
            end
        end
    endtask

    task automatic queue_word(input logic [WORD_W-1:0] w, input logic sof);
        rle_item_t it;
        it.word = w;
        it.sof = sof;
        words_to_send.push_back(it);
        words_queued++;
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN_X:     cfg_org_x = val[COORD_W-1:0];
            REG_ORIGIN_Y:     cfg_org_y = val[COORD_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = val[COUNT_W-1:0];
            default:          ;
        endcase
    endtask

    // upper data bits are junk, the registers keep only their own width
    task automatic set_placement(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                 input logic [COUNT_W-1:0] h);
        reg_write(REG_ORIGIN_X, {16'($urandom), x});
        reg_write(REG_ORIGIN_Y, {16'($urandom), y});
        reg_write(REG_IMAGE_HEIGHT, {17'($urandom), h});
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_to_send.size() != 0 || drv_valid || writes_due.size() != 0);
        // words that draw nothing may still sit in the pipeline
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pick_placement(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y,
                                  output logic [COUNT_W-1:0] h);
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 6))
                0:       x = 16'h8000;
                1:       x = 16'h7fff;
                2:       x = 16'hffff;
                3:       x = 16'd319;
                4:       x = 16'd320;
                5:       x = 16'($urandom);
                default: x = 16'd0;
            endcase
        end else begin
            x = 16'($urandom_range(0, 380) - 40);
        end
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 5))
                0:       y = 16'h8000;
                1:       y = 16'h7fff;
                2:       y = 16'd239;
                3:       y = 16'd240;
                4:       y = 16'hfff9;
                default: y = 16'($urandom);
            endcase
        end else begin
            y = 16'($urandom_range(0, 246) - 8);
        end
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
                0:       h = 15'd0;
                1:       h = 15'h7fff;
                2:       h = 15'd240;
                default: h = 15'd1;
            endcase
        end else begin
            h = 15'($urandom_range(1, 6));
        end
    endtask

    // one encoded image: rows of spans and skips, each row closed by a zero word
    task automatic gen_image();
        int rows;
        int ops;
        int kind;
        int n;
        int cut;
        int start_count;
        bit first;
        rows = (cfg_height > 6) ? 6 : int'(cfg_height);
        rows = rows + $urandom_range(0, 1);
        if (rows == 0)
            rows = 1;
        start_count = words_queued;
        cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 30) : -1;
        first = 1'b1;
        for (int r = 0; r < rows; r++) begin
            ops = $urandom_range(1, 5);
            for (int o = 0; o < ops; o++) begin
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    if (kind < 3)
                        n = 0;
                    else if (kind < 8)
                        n = $urandom_range(11, 40);
                    else
                        n = $urandom_range(1, 10);
                    queue_word({1'b1, COUNT_W'(n)}, first);
                    first = 1'b0;
                    for (int p = 0; p < n; p++)
                        queue_word(WORD_W'($urandom_range(0, 65535)), 1'b0);
                end else if (kind < 88) begin
                    n = (kind < 86) ? $urandom_range(1, 24) : $urandom_range(1, 32767);
                    queue_word({1'b0, COUNT_W'(n)}, first);
                    first = 1'b0;
                end else if (kind < 94) begin
                    queue_word('0, first);
                    first = 1'b0;
                end else begin
                    queue_word(WORD_W'($urandom_range(0, 65535)),
                               first | ($urandom_range(0, 15) == 0));
                    first = 1'b0;
                end
            end
            queue_word('0, first);
            first = 1'b0;
        end
        // broken image: drop its tail, the next start recovers
        if (cut > 0) begin
            while (words_queued > start_count + cut) begin
                void'(words_to_send.pop_back());
                words_queued--;
            end
        end
    endtask

    // stream driver: bursts of random length with random gaps
    always @(posedge clk) begin : driver
        logic      v;
        rle_item_t it;
        v = drv_valid;
        it.word = drv_word;
        it.sof = drv_sof;
        if (rst_n) begin
            if (drv_valid && stream_ch.ready) begin
                blit_word(drv_word, drv_sof);
                words_accepted <= words_accepted + 1;
                v = 1'b0;
            end
            if (!v) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (words_to_send.size() != 0) begin
                    it = words_to_send.pop_front();
                    v = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                                  : $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
        drv_valid <= v;
        drv_word <= it.word;
        drv_sof <= it.sof;
    end

    // pixel receiver: random stall patterns, occasional long holds
    always @(posedge clk) begin : receiver
        logic rdy;
        rdy = rcv_ready;
        if (rst_n) begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                rdy = 1'b0;
            end else if (words_accepted >= HOLD_TRIGGER && !long_hold_done) begin
                // long hold while the stream keeps coming, fills the block
                hold_left <= HOLD_CYCLES;
                long_hold_done <= 1'b1;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rcv_mode <= $urandom_range(0, 3);
                    mode_left <= $urandom_range(32, 400);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (rcv_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 3) != 0);
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = (cycle_count[1:0] == 2'b00);
                endcase
                if ($urandom_range(0, 2999) == 0)
                    hold_left <= $urandom_range(60, 200);
            end
        end
        rcv_ready <= rdy;
    end

    always @(posedge clk) begin : monitor
        pixel_write_t want;
        if (rst_n && pixel_ch.valid && rcv_ready) begin
            if (writes_due.size() == 0) begin
                $error("pixel write with none due: fb_address %0d pixel_value 0x%04h",
                       pixel_ch.fb_address, pixel_ch.pixel_value);
                fail_count++;
            end else begin
                want = writes_due.pop_front();
                if (pixel_ch.fb_address !== want.addr) begin
                    $error("fb_address: expected %0d, got %0d", want.addr, pixel_ch.fb_address);
                    fail_count++;
                end
                if (pixel_ch.pixel_value !== want.value) begin
                    $error("pixel_value: expected 0x%04h, got 0x%04h",
                           want.value, pixel_ch.pixel_value);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COUNT_W-1:0] h;
        int                 phase_words;
        int                 phase_start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle after reset, then an empty image with the reset registers
        queue_word(16'h8002, 1'b0);
        queue_word(16'hffff, 1'b0);
        queue_word(16'h8001, 1'b1);
        queue_word(16'habcd, 1'b0);
        wait_drained();

        // bottom-right corner, right clip, zero span, last row reached
        set_placement(16'd318, 16'd239, 15'd2);
        queue_word(16'h8003, 1'b1);
        queue_word(16'h0000, 1'b0);
        queue_word(16'hffff, 1'b0);
        queue_word(16'h5555, 1'b0);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h0001, 1'b0);
        queue_word(16'h0000, 1'b0);
        wait_drained();

        // rows far above the framebuffer
        set_placement(16'h8000, 16'h8000, 15'h7fff);
        queue_word(16'h8002, 1'b1);
        queue_word(16'h1234, 1'b0);
        queue_word(16'hedcb, 1'b0);
        queue_word(16'h0000, 1'b0);
        wait_drained();

        // column runs into saturation
        set_placement(16'h7fff, 16'd0, 15'd1);
        queue_word(16'h7fff, 1'b1);
        queue_word(16'h7fff, 1'b0);
        queue_word(16'h8001, 1'b0);
        queue_word(16'h2222, 1'b0);
        queue_word(16'h0000, 1'b0);
        wait_drained();

        // restart in the middle of a long span
        set_placement(16'd0, 16'd0, 15'd3);
        queue_word(16'hffff, 1'b1);
        queue_word(16'h0001, 1'b0);
        queue_word(16'h8001, 1'b1);
        queue_word(16'h8000, 1'b0);
        queue_word(16'h0000, 1'b0);
        wait_drained();

        while (words_queued < RANDOM_WORDS) begin
            pick_placement(x, y, h);
            set_placement(x, y, h);
            phase_words = $urandom_range(120, 260);
            phase_start = words_queued;
            while (words_queued - phase_start < phase_words)
                gen_image();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && writes_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
